@@ hw/rtl/vrp_pkg.sv @@
// shared types, codes and constants of the video register port
package vrp_pkg;

    localparam int OBJECT_RAM_BYTES  = 256;
    localparam int NAME_RAM_BYTES_DF = 2048;
    localparam int OBJ_AW            = $clog2(OBJECT_RAM_BYTES);
    localparam int PAL_ENTRIES       = 16;

    // request functions
    localparam logic [1:0] FUNC_WRITE  = 2'd0;
    localparam logic [1:0] FUNC_READ   = 2'd1;
    localparam logic [1:0] FUNC_STATUS = 2'd2;

    // register indexes within the port
    localparam logic [2:0] REG_CONTROL  = 3'd0;
    localparam logic [2:0] REG_MASK     = 3'd1;
    localparam logic [2:0] REG_STATUS   = 3'd2;
    localparam logic [2:0] REG_OBJ_ADDR = 3'd3;
    localparam logic [2:0] REG_OBJ_DATA = 3'd4;
    localparam logic [2:0] REG_SCROLL   = 3'd5;
    localparam logic [2:0] REG_ADDR     = 3'd6;
    localparam logic [2:0] REG_DATA     = 3'd7;

    // configuration register byte addresses
    localparam logic [1:0] CFG_ADDR_MIRROR = 2'd0;

    localparam logic [15:0] NAME_BASE    = 16'h2000;
    localparam logic [15:0] PALETTE_BASE = 16'h3F00;
    localparam logic [15:0] SPACE_END    = 16'h4000;
    localparam logic [7:0]  SCROLL_V_MAX = 8'd239;
    localparam logic [15:0] STEP_COLUMN  = 16'd1;
    localparam logic [15:0] STEP_ROW     = 16'd32;
    localparam logic [8:0]  LINE_LOW     = 9'd20;
    localparam logic [8:0]  LINE_END     = 9'd262;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } vrp_state_t;

    typedef enum logic [1:0] {
        SP_PATTERN,
        SP_NAME,
        SP_PALETTE,
        SP_NONE
    } vrp_space_t;

    typedef struct packed {
        logic load;
        logic commit;
    } vrp_cmd_t;

    function automatic vrp_space_t space_of(input logic [15:0] addr);
        vrp_space_t sp;
        if (addr < NAME_BASE)
            sp = SP_PATTERN;
        else if (addr < PALETTE_BASE)
            sp = SP_NAME;
        else if (addr < SPACE_END)
            sp = SP_PALETTE;
        else
            sp = SP_NONE;
        return sp;
    endfunction

endpackage

@@ hw/rtl/vrp_ram.sv @@
// generic single-port-write ram with registered read
module vrp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ hw/rtl/vrp_ctrl.sv @@
// request sequencer: accept, execute, result strobe
module vrp_ctrl
    import vrp_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    output logic     done,
    output vrp_cmd_t cmd
);

    vrp_state_t state_reg, state_next;
    logic       done_reg, done_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                cmd.commit = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        done_next = cmd.commit;
    end

    assign busy = (state_reg == ST_EXEC);
    assign done = done_reg;

endmodule

@@ hw/rtl/vrp_datapath.sv @@
// register file, memories and access logic of the video register port
module vrp_datapath
    import vrp_pkg::*;
#(
    parameter int NAME_RAM_BYTES = NAME_RAM_BYTES_DF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  vrp_cmd_t    cmd,
    input  logic        mirror_vertical,
    input  logic [1:0]  func,
    input  logic [2:0]  reg_index,
    input  logic [7:0]  write_data,
    input  logic [7:0]  chr_data,
    input  logic [8:0]  scanline,
    output logic [7:0]  read_data,
    output logic [15:0] vram_address,
    output logic [7:0]  control_byte,
    output logic [7:0]  mask_byte,
    output logic [7:0]  scroll_h,
    output logic [7:0]  scroll_v
);

    localparam int NAME_AW = $clog2(NAME_RAM_BYTES);

    // latched request
    logic [1:0] func_reg;
    logic [2:0] reg_idx_reg;
    logic [7:0] wdata_reg;
    logic [7:0] chr_reg;
    logic [8:0] line_reg;

    logic [7:0]  control_reg, control_next;
    logic [7:0]  mask_reg, mask_next;
    logic [7:0]  status_reg, status_next;
    logic [7:0]  obj_ptr_reg, obj_ptr_next;
    logic        toggle_reg, toggle_next;
    logic [7:0]  scroll_h_reg, scroll_h_next;
    logic [7:0]  scroll_v_reg, scroll_v_next;
    logic [15:0] vram_reg, vram_next;
    logic [7:0]  rbuf_reg, rbuf_next;
    logic [7:0]  rd_reg, rd_next;
    logic [7:0]  bg_pal_reg [PAL_ENTRIES];
    logic [7:0]  bg_pal_next [PAL_ENTRIES];
    logic [7:0]  obj_pal_reg [PAL_ENTRIES];
    logic [7:0]  obj_pal_next [PAL_ENTRIES];
    logic [OBJECT_RAM_BYTES-1:0] obj_valid_reg;

    logic               obj_we;
    logic [7:0]         obj_rdata;
    logic               name_we;
    logic [NAME_AW-1:0] name_addr;
    logic [7:0]         name_rdata;
    logic [1:0]         nt_table;
    logic               nt_bank;
    vrp_space_t         space;
    logic [7:0]         pal_rdata;
    logic [15:0]        step;

    // both ram addresses come from state that holds still until commit
    vrp_ram #(
        .WIDTH (8),
        .DEPTH (OBJECT_RAM_BYTES)
    ) u_obj_ram (
        .clk   (clk),
        .we    (obj_we),
        .waddr (obj_ptr_reg[OBJ_AW-1:0]),
        .wdata (wdata_reg),
        .raddr (obj_ptr_reg[OBJ_AW-1:0]),
        .rdata (obj_rdata)
    );

    vrp_ram #(
        .WIDTH (8),
        .DEPTH (NAME_RAM_BYTES)
    ) u_name_ram (
        .clk   (clk),
        .we    (name_we),
        .waddr (name_addr),
        .wdata (wdata_reg),
        .raddr (name_addr),
        .rdata (name_rdata)
    );

    assign nt_table  = vram_reg[11:10];
    assign nt_bank   = mirror_vertical ? nt_table[0] : nt_table[1];
    assign name_addr = NAME_AW'({nt_bank, vram_reg[9:0]});
    assign space     = space_of(vram_reg);
    assign pal_rdata = vram_reg[4] ? obj_pal_reg[vram_reg[3:0]]
                                   : bg_pal_reg[vram_reg[3:0]];
    assign step      = control_reg[2] ? STEP_ROW : STEP_COLUMN;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg    <= func;
            reg_idx_reg <= reg_index;
            wdata_reg   <= write_data;
            chr_reg     <= chr_data;
            line_reg    <= scanline;
        end
    end

    always_comb
    begin
        control_next  = control_reg;
        mask_next     = mask_reg;
        status_next   = status_reg;
        obj_ptr_next  = obj_ptr_reg;
        toggle_next   = toggle_reg;
        scroll_h_next = scroll_h_reg;
        scroll_v_next = scroll_v_reg;
        vram_next     = vram_reg;
        rbuf_next     = rbuf_reg;
        rd_next       = 8'd0;
        bg_pal_next   = bg_pal_reg;
        obj_pal_next  = obj_pal_reg;
        obj_we        = 1'b0;
        name_we       = 1'b0;

        unique case (func_reg)
            FUNC_WRITE:
            begin
                unique case (reg_idx_reg)
                    REG_CONTROL:  control_next = wdata_reg;
                    REG_MASK:     mask_next    = wdata_reg;
                    REG_OBJ_ADDR: obj_ptr_next = wdata_reg;
                    REG_OBJ_DATA:
                    begin
                        obj_we       = cmd.commit;
                        obj_ptr_next = obj_ptr_reg + 8'd1;
                    end
                    REG_SCROLL:
                    begin
                        if (toggle_reg)
                            scroll_v_next = (wdata_reg > SCROLL_V_MAX) ? 8'd0 : wdata_reg;
                        else
                            scroll_h_next = wdata_reg;
                        toggle_next = !toggle_reg;
                    end
                    REG_ADDR:
                    begin
                        vram_next   = {vram_reg[7:0], wdata_reg};
                        toggle_next = !toggle_reg;
                    end
                    REG_DATA:
                    begin
                        if (space == SP_NAME)
                        begin
                            name_we = cmd.commit;
                        end
                        else if (space == SP_PALETTE)
                        begin
                            if (vram_reg[4])
                            begin
                                obj_pal_next[vram_reg[3:0]] = wdata_reg;
                                // a backdrop write to the object palette goes to every backdrop entry of both palettes
                                if (vram_reg[1:0] == 2'd0)
                                begin
                                    for (int i = 0; i < PAL_ENTRIES; i += 4)
                                    begin
                                        obj_pal_next[i] = wdata_reg;
                                        bg_pal_next[i]  = wdata_reg;
                                    end
                                end
                            end
                            else
                            begin
                                bg_pal_next[vram_reg[3:0]] = wdata_reg;
                            end
                        end
                        vram_next = vram_reg + step;
                    end
                    default: ;
                endcase
            end
            FUNC_READ:
            begin
                unique case (reg_idx_reg) inside
                    REG_CONTROL: rd_next = control_reg;
                    REG_MASK:    rd_next = mask_reg;
                    REG_STATUS:
                    begin
                        rd_next     = status_reg;
                        status_next = {1'b0, status_reg[6:0]};
                        toggle_next = 1'b0;
                        if (line_reg > LINE_LOW && line_reg < LINE_END && !control_reg[7])
                            control_next = {control_reg[7:2], 2'b00};
                    end
                    REG_OBJ_DATA:
                    begin
                        rd_next      = obj_valid_reg[obj_ptr_reg[OBJ_AW-1:0]] ? obj_rdata : 8'd0;
                        obj_ptr_next = obj_ptr_reg + 8'd1;
                    end
                    REG_DATA:
                    begin
                        rd_next = rbuf_reg;
                        case (space)
                            SP_PATTERN: rbuf_next = chr_reg;
                            SP_NAME:    rbuf_next = name_rdata;
                            SP_PALETTE: rd_next   = pal_rdata;
                            default:    rd_next   = 8'd0;
                        endcase
                        vram_next = vram_reg + step;
                    end
                    REG_OBJ_ADDR, REG_SCROLL, REG_ADDR: rd_next = {5'd0, reg_idx_reg};
                    default: ;
                endcase
            end
            FUNC_STATUS: status_next = wdata_reg;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            control_reg   <= '0;
            mask_reg      <= '0;
            status_reg    <= '0;
            obj_ptr_reg   <= '0;
            toggle_reg    <= 1'b0;
            scroll_h_reg  <= '0;
            scroll_v_reg  <= '0;
            vram_reg      <= '0;
            rbuf_reg      <= '0;
            obj_valid_reg <= '0;
            for (int i = 0; i < PAL_ENTRIES; i++)
            begin
                bg_pal_reg[i]  <= '0;
                obj_pal_reg[i] <= '0;
            end
        end
        else if (cmd.commit)
        begin
            control_reg  <= control_next;
            mask_reg     <= mask_next;
            status_reg   <= status_next;
            obj_ptr_reg  <= obj_ptr_next;
            toggle_reg   <= toggle_next;
            scroll_h_reg <= scroll_h_next;
            scroll_v_reg <= scroll_v_next;
            vram_reg     <= vram_next;
            rbuf_reg     <= rbuf_next;
            bg_pal_reg   <= bg_pal_next;
            obj_pal_reg  <= obj_pal_next;
            if (obj_we)
            begin
                obj_valid_reg[obj_ptr_reg[OBJ_AW-1:0]] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            rd_reg <= rd_next;
        end
    end

    assign read_data    = rd_reg;
    assign vram_address = vram_reg;
    assign control_byte = control_reg;
    assign mask_byte    = mask_reg;
    assign scroll_h     = scroll_h_reg;
    assign scroll_v     = scroll_v_reg;

endmodule

@@ hw/rtl/video_register_port_top.sv @@
// top level of the video register port
//
//  channel   handshake                          payload
//  request   start, accepted when busy is low   func, reg_index, write_data, chr_data, scanline
//  result    done, one cycle, no back-pressure  read_data, vram_address, control_byte,
//                                               mask_byte, scroll_h, scroll_v
//  config    apb write, psel&penable&pwrite     paddr, pwdata (mirror_vertical at 0)
//
// each request has an accept cycle and an execute cycle: the accept cycle presents the ram addresses,
// the execute cycle uses the registered ram read data and updates all state
// the result strobe follows in the next cycle, while a new request may be accepted
// reset clears the port state, object ram valid bits and palette entries at once
// name ram contents stay undefined until written
module video_register_port_top
    import vrp_pkg::*;
#(
    parameter int NAME_RAM_BYTES = NAME_RAM_BYTES_DF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  func,
    input  logic [2:0]  reg_index,
    input  logic [7:0]  write_data,
    input  logic [7:0]  chr_data,
    input  logic [8:0]  scanline,
    output logic        done,
    output logic [7:0]  read_data,
    output logic [15:0] vram_address,
    output logic [7:0]  control_byte,
    output logic [7:0]  mask_byte,
    output logic [7:0]  scroll_h,
    output logic [7:0]  scroll_v,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    vrp_cmd_t cmd;
    logic     mirror_reg;
    logic     cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr == CFG_ADDR_MIRROR);
    assign prdata = (paddr == CFG_ADDR_MIRROR) ? {31'd0, mirror_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mirror_reg <= 1'b0;
        end
        else if (cfg_wr)
        begin
            mirror_reg <= pwdata[0];
        end
    end

    vrp_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd)
    );

    vrp_datapath #(
        .NAME_RAM_BYTES (NAME_RAM_BYTES)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .mirror_vertical (mirror_reg),
        .func            (func),
        .reg_index       (reg_index),
        .write_data      (write_data),
        .chr_data        (chr_data),
        .scanline        (scanline),
        .read_data       (read_data),
        .vram_address    (vram_address),
        .control_byte    (control_byte),
        .mask_byte       (mask_byte),
        .scroll_h        (scroll_h),
        .scroll_v        (scroll_v)
    );

    a_exec_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> !busy)
        else $error("execute phase longer than one cycle");

    a_accept_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not enter execute");

    a_strobe_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> done)
        else $error("result strobe missing after execute");

    a_strobe_only_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result strobe without a request");

    a_scroll_v_range: assert property (@(posedge clk) disable iff (!rst_n)
        scroll_v <= SCROLL_V_MAX)
        else $error("vertical scroll out of range");

endmodule
